// ===== src/wcpf_pkg.sv =====
// ----------------------------------------------------------------------------
// WAV chunk parser/framer package
// Shared types and constants for the RIFF/WAVE PCM16 parser and its framer.
// ----------------------------------------------------------------------------
package wcpf_pkg;

   // Chunk tags, first byte of the tag in the top byte.
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // Format that the fmt chunk must declare besides the sample rate.
   localparam logic [15:0] BITS_REQUIRED     = 16'd16;
   localparam logic [15:0] CHANNELS_REQUIRED = 16'd1;
   localparam logic [31:0] FMT_BODY_BYTES    = 32'd16;

   // Reset value of the required sample rate register.
   localparam logic [31:0] REQUIRED_RATE_RESET = 32'd8000;

   // Samples per frame by default.
   localparam int FRAME_SAMPLES_DEFAULT = 80;

   // Parser phases.
   typedef enum logic [3:0] {
      PH_FIRST    = 4'd0,
      PH_TAG      = 4'd1,
      PH_RIFFSIZE = 4'd2,
      PH_FMTSIZE  = 4'd3,
      PH_FMTBODY  = 4'd4,
      PH_SKIP     = 4'd5,
      PH_DATASIZE = 4'd6,
      PH_DATA     = 4'd7,
      PH_UNKSIZE  = 4'd8
   } phase_type;

   // Result kinds.
   typedef enum logic [2:0] {
      KIND_SAMPLE     = 3'd0,
      KIND_FMT_OK     = 3'd1,
      KIND_DATA_START = 3'd2,
      KIND_NOT_RIFF   = 3'd3,
      KIND_BAD_FORMAT = 3'd4
   } kind_type;

   // One result item.
   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] sample;
      logic               frame_last;
      logic [31:0]        chunk_length;
   } result_type;

   // Result of one parser step.
   typedef struct packed {
      logic       valid;
      result_type payload;
   } step_result_type;

endpackage

// ===== src/wcpf_req_if.sv =====
// ----------------------------------------------------------------------------
// WAV parser byte channel
// Valid/ready channel that carries one file byte and the new-stream mark.
// ----------------------------------------------------------------------------
interface wcpf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       stream_start;

   modport source (output valid, output stream_byte, output stream_start, input ready);
   modport sink   (input valid, input stream_byte, input stream_start, output ready);
endinterface

// ===== src/wcpf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// WAV parser result channel
// Valid/ready channel that carries decoded samples and parser events.
// ----------------------------------------------------------------------------
interface wcpf_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [15:0] sample;
   logic               frame_last;
   logic [31:0]        chunk_length;

   modport source (output valid, output kind, output sample, output frame_last,
                   output chunk_length, input ready);
   modport sink   (input valid, input kind, input sample, input frame_last,
                   input chunk_length, output ready);
endinterface

// ===== src/wcpf_parser.sv =====
// ----------------------------------------------------------------------------
// WAV chunk parser
// Holds the parse state and advances it by one file byte per step, giving
// at most one result for that byte.
// ----------------------------------------------------------------------------
module wcpf_parser
   import wcpf_pkg::*;
#(
   parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic [7:0]      step_byte,
   input  logic            step_start,
   input  logic [31:0]     required_rate,
   output step_result_type result
);

   localparam int POS_W = $clog2(FRAME_SAMPLES + 1);
   localparam logic [POS_W-1:0] FRAME_LAST_POS = POS_W'(FRAME_SAMPLES);

   phase_type        phase_ff, phase_in;
   logic [31:0]      tag_ff, tag_in;
   logic [31:0]      size_ff, size_in;
   logic [31:0]      count_ff, count_in;
   logic [15:0]      fmt_tag_ff, fmt_tag_in;
   logic [15:0]      chans_ff, chans_in;
   logic [31:0]      rate_ff, rate_in;
   logic [15:0]      bits_ff, bits_in;
   logic [7:0]       low_ff, low_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             stopped_ff, stopped_in;

   logic [31:0]      count_inc;
   logic [POS_W-1:0] pos_inc;
   logic             fmt_ok;
   logic             high_byte;

   // Next state and result for the byte in the input register.
   always_comb begin
      phase_in   = phase_ff;
      tag_in     = tag_ff;
      size_in    = size_ff;
      count_in   = count_ff;
      fmt_tag_in = fmt_tag_ff;
      chans_in   = chans_ff;
      rate_in    = rate_ff;
      bits_in    = bits_ff;
      low_in     = low_ff;
      pos_in     = pos_ff;
      stopped_in = stopped_ff;
      result     = '0;

      // A new stream clears everything and the byte is parsed as its first.
      if (step_start) begin
         phase_in   = PH_FIRST;
         tag_in     = '0;
         size_in    = '0;
         count_in   = '0;
         fmt_tag_in = '0;
         chans_in   = '0;
         rate_in    = '0;
         bits_in    = '0;
         low_in     = '0;
         pos_in     = '0;
         stopped_in = 1'b0;
      end

      count_inc = count_in + 32'd1;
      pos_inc   = pos_in + POS_W'(1);
      fmt_ok    = (bits_in == BITS_REQUIRED) && (chans_in == CHANNELS_REQUIRED);
      // Bytes consumed so far in the data chunk is size minus bytes left.
      high_byte = size_in[0] ^ count_in[0];

      if (!stopped_in) begin
         case (phase_in)
            PH_FIRST, PH_TAG: begin
               tag_in   = {tag_in[23:0], step_byte};
               count_in = count_inc;
               if (count_inc >= 32'd4) begin
                  count_in = '0;
                  if (tag_in == TAG_RIFF) begin
                     phase_in = PH_RIFFSIZE;
                     size_in  = '0;
                  end else if (phase_in == PH_FIRST) begin
                     stopped_in          = 1'b1;
                     result.valid        = 1'b1;
                     result.payload.kind = KIND_NOT_RIFF;
                  end else if (tag_in == TAG_WAVE) begin
                     phase_in = PH_TAG;
                     tag_in   = '0;
                  end else if (tag_in == TAG_FMT) begin
                     phase_in = PH_FMTSIZE;
                     size_in  = '0;
                  end else if (tag_in == TAG_DATA) begin
                     phase_in = PH_DATASIZE;
                     size_in  = '0;
                  end else begin
                     phase_in = PH_UNKSIZE;
                     size_in  = '0;
                  end
               end
            end

            PH_RIFFSIZE, PH_FMTSIZE, PH_DATASIZE, PH_UNKSIZE: begin
               size_in  = {step_byte, size_in[31:8]};
               count_in = count_inc;
               if (count_inc >= 32'd4) begin
                  case (phase_in)
                     PH_RIFFSIZE: begin
                        phase_in = PH_TAG;
                        tag_in   = '0;
                        count_in = '0;
                     end
                     PH_FMTSIZE: begin
                        phase_in   = PH_FMTBODY;
                        count_in   = '0;
                        fmt_tag_in = '0;
                        chans_in   = '0;
                        rate_in    = '0;
                        bits_in    = '0;
                     end
                     PH_DATASIZE: begin
                        count_in = size_in;
                        if (size_in == '0) begin
                           phase_in = PH_TAG;
                           tag_in   = '0;
                        end else begin
                           phase_in = PH_DATA;
                        end
                        result.valid                = 1'b1;
                        result.payload.kind         = KIND_DATA_START;
                        result.payload.chunk_length = size_in;
                     end
                     default: begin
                        count_in = size_in;
                        if (size_in == '0) begin
                           phase_in = PH_TAG;
                           tag_in   = '0;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end
                  endcase
               end
            end

            PH_FMTBODY: begin
               // Pick the fmt field that this body byte belongs to.
               case (count_in[3:0])
                  4'd0:    fmt_tag_in[7:0]  = step_byte;
                  4'd1:    fmt_tag_in[15:8] = step_byte;
                  4'd2:    chans_in[7:0]    = step_byte;
                  4'd3:    chans_in[15:8]   = step_byte;
                  4'd4:    rate_in[7:0]     = step_byte;
                  4'd5:    rate_in[15:8]    = step_byte;
                  4'd6:    rate_in[23:16]   = step_byte;
                  4'd7:    rate_in[31:24]   = step_byte;
                  4'd14:   bits_in[7:0]     = step_byte;
                  4'd15:   bits_in[15:8]    = step_byte;
                  default: ;
               endcase
               count_in = count_inc;
               if (count_inc >= FMT_BODY_BYTES) begin
                  result.valid = 1'b1;
                  if ((rate_in != required_rate) || (bits_in != BITS_REQUIRED) ||
                      (chans_in != CHANNELS_REQUIRED)) begin
                     stopped_in          = 1'b1;
                     result.payload.kind = KIND_BAD_FORMAT;
                  end else begin
                     result.payload.kind = KIND_FMT_OK;
                     if (size_in > FMT_BODY_BYTES) begin
                        count_in = size_in - FMT_BODY_BYTES;
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_TAG;
                        tag_in   = '0;
                        count_in = '0;
                     end
                  end
               end
            end

            PH_SKIP: begin
               if (count_in != '0) begin
                  count_in = count_in - 32'd1;
               end
               if (count_in == '0) begin
                  phase_in = PH_TAG;
                  tag_in   = '0;
               end
            end

            PH_DATA: begin
               if (count_in != '0) begin
                  count_in = count_in - 32'd1;
               end
               if (!high_byte) begin
                  low_in = step_byte;
               end else if (fmt_ok) begin
                  result.valid          = 1'b1;
                  result.payload.kind   = KIND_SAMPLE;
                  result.payload.sample = {step_byte, low_in};
                  if (pos_inc >= FRAME_LAST_POS) begin
                     pos_in                    = '0;
                     result.payload.frame_last = 1'b1;
                  end else begin
                     pos_in = pos_inc;
                  end
               end
               if (count_in == '0) begin
                  phase_in = PH_TAG;
                  tag_in   = '0;
               end
            end

            default: begin
               phase_in = PH_TAG;
               tag_in   = '0;
               count_in = '0;
            end
         endcase
      end
   end

   // Parse state registers, advanced once per byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FIRST;
         tag_ff     <= '0;
         size_ff    <= '0;
         count_ff   <= '0;
         fmt_tag_ff <= '0;
         chans_ff   <= '0;
         rate_ff    <= '0;
         bits_ff    <= '0;
         low_ff     <= '0;
         pos_ff     <= '0;
         stopped_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         tag_ff     <= tag_in;
         size_ff    <= size_in;
         count_ff   <= count_in;
         fmt_tag_ff <= fmt_tag_in;
         chans_ff   <= chans_in;
         rate_ff    <= rate_in;
         bits_ff    <= bits_in;
         low_ff     <= low_in;
         pos_ff     <= pos_in;
         stopped_ff <= stopped_in;
      end
   end

   // A stopped stream gives nothing until a new stream begins.
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (step_en && stopped_ff && !step_start) |-> !result.valid)
      else $error("result produced while the stream is stopped");

   // A not-RIFF or bad-format result leaves the parser stopped.
   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.valid && ((result.payload.kind == KIND_NOT_RIFF) ||
       (result.payload.kind == KIND_BAD_FORMAT))) |=> stopped_ff)
      else $error("error result did not stop the stream");

   // The frame position never reaches the frame length.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < FRAME_LAST_POS)
      else $error("frame position out of range");

   // Only samples can close a frame.
   a_last_on_sample: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.payload.frame_last) |-> (result.payload.kind == KIND_SAMPLE))
      else $error("frame end marked on a non-sample result");

endmodule

// ===== src/wav_chunk_parser_framer_core.sv =====
// A byte transfer loads the input register; its result, if any, is then registered in the
// output register, from which it transfers on the result channel.
// Throughput: one byte per cycle; the parser state advances once per byte.
// The input register stalls only while a result waits at the output.
// Reset (synchronous): clears both pipeline registers and all parse state,
// and sets the required sample rate to 8000.
// ----------------------------------------------------------------------------
// WAV chunk parser/framer top level
// Parses a RIFF/WAVE PCM16 mono byte stream and delivers samples with frame
// ends and chunk events over a valid/ready result channel.
// ----------------------------------------------------------------------------
module wav_chunk_parser_framer_core
   import wcpf_pkg::*;
#(
   parameter int FRAME_SAMPLES = FRAME_SAMPLES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   wcpf_req_if.sink    req_chan,
   wcpf_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   logic [31:0]     rate_ff;
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_start_ff;
   logic            out_valid_ff, out_valid_in;
   result_type      out_ff;
   logic            advance;
   logic            step_en;
   step_result_type step_result;

   // The input register moves on whenever the output register is free.
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign step_en        = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   // Required sample rate register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= REQUIRED_RATE_RESET;
      end else if (csr_write_enable) begin
         rate_ff <= csr_write_data;
      end
   end

   // Input register control.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff  <= req_chan.stream_byte;
         in_start_ff <= req_chan.stream_start;
      end
   end

   // Parse state and per-byte step.
   wcpf_parser #(
      .FRAME_SAMPLES (FRAME_SAMPLES)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .step_byte     (in_byte_ff),
      .step_start    (in_start_ff),
      .required_rate (rate_ff),
      .result        (step_result)
   );

   // Output register control: a transfer empties it, a step may refill it.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (step_en) begin
         out_valid_in = step_result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && step_result.valid) begin
         out_ff <= step_result.payload;
      end
   end

   // Result channel.
   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.kind         = out_ff.kind;
   assign rsp_chan.sample       = out_ff.sample;
   assign rsp_chan.frame_last   = out_ff.frame_last;
   assign rsp_chan.chunk_length = out_ff.chunk_length;

endmodule
